FILE: hw/rtl/mrp_pkg.sv
// Shared types, constants and base table for the Miller-Rabin primality tester.
`default_nettype none

package mrp_pkg;

    // Number of entries in the fixed base table and width of one base.
    localparam int unsigned BaseCount = 10;
    localparam int unsigned BaseWidth = 15;
    localparam int unsigned BaseIdxWidth = 4;

    typedef logic [BaseWidth-1:0]    t_base;
    typedef logic [BaseIdxWidth-1:0] t_base_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TZ,
        S_BASE,
        S_POW,
        S_POW_RES_WAIT,
        S_POW_SQ,
        S_POW_SQ_WAIT,
        S_CHK0,
        S_SQR,
        S_SQR_WAIT,
        S_FINISH
    } t_state;

    // Fixed witness bases, in the order they are tried.
    function automatic t_base base_of(input t_base_idx idx);
        t_base b;
        case (idx)
            4'd0:    b = 15'd2;
            4'd1:    b = 15'd3;
            4'd2:    b = 15'd5;
            4'd3:    b = 15'd7;
            4'd4:    b = 15'd11;
            4'd5:    b = 15'd13;
            4'd6:    b = 15'd17;
            4'd7:    b = 15'd53;
            4'd8:    b = 15'd61;
            4'd9:    b = 15'd24251;
            default: b = 15'd2;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mrp_mulmod.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
`default_nettype none

module mrp_mulmod #(
    parameter int unsigned W = 63
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_x,
    input  wire logic [W-1:0] i_y,
    input  wire logic [W-1:0] i_m,
    output logic              o_done,
    output logic [W-1:0]      o_product
);

    localparam int unsigned E  = W + 3;
    localparam int unsigned CW = $clog2(W + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_acc, n_acc;
    logic [W-1:0]  r_x, n_x;
    logic [W-1:0]  r_y, n_y;

    logic [E-1:0]  a, xe, me, am, ax, axm, axm2, step;

    always_comb begin
        // Double the accumulator, optionally add x, then pick the candidate
        // that lands in [0, m); all candidates are formed side by side.
        a    = {2'b00, r_acc, 1'b0};
        xe   = {3'b000, r_x};
        me   = {3'b000, i_m};
        am   = a - me;
        ax   = a + xe;
        axm  = ax - me;
        axm2 = ax - {2'b00, i_m, 1'b0};
        if (r_y[W-1]) begin
            if (axm[E-1]) begin
                step = ax;
            end else if (axm2[E-1]) begin
                step = axm;
            end else begin
                step = axm2;
            end
        end else begin
            step = am[E-1] ? a : am;
        end

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_x    = r_x;
        n_y    = r_y;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(W);
            n_acc  = '0;
            n_x    = i_x;
            n_y    = i_y;
        end else if (r_busy) begin
            n_acc = step[W-1:0];
            n_y   = {r_y[W-2:0], 1'b0};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

`default_nettype wire

FILE: hw/rtl/miller_rabin_primality_test.sv
// Deterministic Miller-Rabin primality tester, one value per item.
// Usage:
//   Input channel (i_valid, o_stall, i_value): an item is taken at a rising
//   edge with i_valid high and o_stall low. o_stall is high while an item is
//   being tested, so one item is in work at a time.
//   Output channel (o_valid, i_stall, o_is_prime): one result item per input
//   item, in order. The result sits in an output register and holds while
//   i_stall is high; a new item may be taken while it waits, and that item
//   parks in its final state until the output register is free.
// Flow:
//   2 and even values, 0 and 1: straight from S_IDLE to S_FINISH, with no
//   multiplier use. Odd values: every modular product goes through the
//   bit-serial multiplier, with a start state and a wait state in the controller
//   for each. Per base the test spends up to 2*VALUE_WIDTH products on the power
//   and up to s squarings (s = trailing zeros of value-1). A new item is taken
//   only after the last one has left S_FINISH.
// Reset: i_rst_n synchronous, active low; clears the controller, the multiplier's
//   control and the output valid. There is no other state to clear.
`default_nettype none

module miller_rabin_primality_test #(
    parameter int unsigned NUM_BASES   = 10,
    parameter int unsigned VALUE_WIDTH = 63
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic                        o_is_prime
);

    localparam int unsigned W  = VALUE_WIDTH;
    localparam int unsigned SW = $clog2(W + 1);
    localparam int unsigned IW = $clog2(NUM_BASES + 1);
    localparam int unsigned CW = (W > 16) ? W : 16;

    mrp_pkg::t_state r_state, n_state;

    logic [W-1:0]  r_n, n_n;        // value under test, also the modulus
    logic [W-1:0]  r_nm1, n_nm1;    // value - 1
    logic [W-1:0]  r_d, n_d;        // odd part of value - 1
    logic [SW-1:0] r_s, n_s;        // trailing zero count of value - 1
    logic [IW-1:0] r_idx, n_idx;    // current base index
    logic [W-1:0]  r_res, n_res;    // power result
    logic [W-1:0]  r_b, n_b;        // running square of the base
    logic [W-1:0]  r_e, n_e;        // exponent shift register, LSB first
    logic [W-1:0]  r_t, n_t;        // value under repeated squaring
    logic [SW-1:0] r_k, n_k;        // squarings left
    logic          r_prime, n_prime;
    logic          r_out_valid, n_out_valid;
    logic          r_out, n_out;

    logic          mul_start;
    logic [W-1:0]  mul_x, mul_y;
    logic          mul_done;
    logic [W-1:0]  mul_p;

    mrp_pkg::t_base base;
    logic [CW-1:0]  base_ext, n_ext;
    logic           in_take, out_take, out_free;

    mrp_mulmod #(
        .W (W)
    ) u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_x       (mul_x),
        .i_y       (mul_y),
        .i_m       (r_n),
        .o_done    (mul_done),
        .o_product (mul_p)
    );

    always_comb begin
        in_take  = i_valid && (r_state == mrp_pkg::S_IDLE);
        out_take = r_out_valid && !i_stall;
        out_free = !r_out_valid || !i_stall;

        base     = mrp_pkg::base_of(mrp_pkg::t_base_idx'(r_idx));
        base_ext = CW'(base);
        n_ext    = CW'(r_n);

        n_state     = r_state;
        n_n         = r_n;
        n_nm1       = r_nm1;
        n_d         = r_d;
        n_s         = r_s;
        n_idx       = r_idx;
        n_res       = r_res;
        n_b         = r_b;
        n_e         = r_e;
        n_t         = r_t;
        n_k         = r_k;
        n_prime     = r_prime;
        n_out       = r_out;
        n_out_valid = out_take ? 1'b0 : r_out_valid;

        mul_start = 1'b0;
        mul_x     = r_res;
        mul_y     = r_b;

        case (r_state)
            mrp_pkg::S_IDLE: begin
                if (in_take) begin
                    n_n   = i_value;
                    n_nm1 = i_value - W'(1);
                    n_d   = i_value - W'(1);
                    n_s   = '0;
                    if (i_value == W'(2)) begin
                        n_prime = 1'b1;
                        n_state = mrp_pkg::S_FINISH;
                    end else if (i_value < W'(2) || !i_value[0]) begin
                        n_prime = 1'b0;
                        n_state = mrp_pkg::S_FINISH;
                    end else begin
                        n_state = mrp_pkg::S_TZ;
                    end
                end
            end
            mrp_pkg::S_TZ: begin
                // Strip one trailing zero a cycle.
                if (!r_d[0]) begin
                    n_d = {1'b0, r_d[W-1:1]};
                    n_s = r_s + SW'(1);
                end else begin
                    n_idx   = '0;
                    n_state = mrp_pkg::S_BASE;
                end
            end
            mrp_pkg::S_BASE: begin
                if (r_idx == IW'(NUM_BASES)) begin
                    n_prime = 1'b1;
                    n_state = mrp_pkg::S_FINISH;
                end else if (base_ext < n_ext) begin
                    n_res   = W'(1);
                    n_b     = W'(base);
                    n_e     = r_d;
                    n_state = mrp_pkg::S_POW;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            mrp_pkg::S_POW: begin
                if (r_e[0]) begin
                    mul_start = 1'b1;
                    mul_x     = r_res;
                    mul_y     = r_b;
                    n_state   = mrp_pkg::S_POW_RES_WAIT;
                end else begin
                    n_state = mrp_pkg::S_POW_SQ;
                end
            end
            mrp_pkg::S_POW_RES_WAIT: begin
                if (mul_done) begin
                    n_res   = mul_p;
                    n_state = mrp_pkg::S_POW_SQ;
                end
            end
            mrp_pkg::S_POW_SQ: begin
                // Skip the square after the last exponent bit.
                if (r_e[W-1:1] == '0) begin
                    n_state = mrp_pkg::S_CHK0;
                end else begin
                    mul_start = 1'b1;
                    mul_x     = r_b;
                    mul_y     = r_b;
                    n_state   = mrp_pkg::S_POW_SQ_WAIT;
                end
            end
            mrp_pkg::S_POW_SQ_WAIT: begin
                if (mul_done) begin
                    n_b     = mul_p;
                    n_e     = {1'b0, r_e[W-1:1]};
                    n_state = mrp_pkg::S_POW;
                end
            end
            mrp_pkg::S_CHK0: begin
                n_t = r_res;
                n_k = r_s;
                if (r_res == W'(1) || r_res == r_nm1) begin
                    n_idx   = r_idx + IW'(1);
                    n_state = mrp_pkg::S_BASE;
                end else begin
                    n_state = mrp_pkg::S_SQR;
                end
            end
            mrp_pkg::S_SQR: begin
                mul_start = 1'b1;
                mul_x     = r_t;
                mul_y     = r_t;
                n_state   = mrp_pkg::S_SQR_WAIT;
            end
            mrp_pkg::S_SQR_WAIT: begin
                if (mul_done) begin
                    n_t = mul_p;
                    n_k = r_k - SW'(1);
                    if (mul_p == r_nm1) begin
                        n_idx   = r_idx + IW'(1);
                        n_state = mrp_pkg::S_BASE;
                    end else if (mul_p == W'(1) || r_k == SW'(1)) begin
                        n_prime = 1'b0;
                        n_state = mrp_pkg::S_FINISH;
                    end else begin
                        n_state = mrp_pkg::S_SQR;
                    end
                end
            end
            mrp_pkg::S_FINISH: begin
                // Hold the verdict until the output register is free.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_prime;
                    n_state     = mrp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mrp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mrp_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_nm1   <= n_nm1;
        r_d     <= n_d;
        r_s     <= n_s;
        r_idx   <= n_idx;
        r_res   <= n_res;
        r_b     <= n_b;
        r_e     <= n_e;
        r_t     <= n_t;
        r_k     <= n_k;
        r_prime <= n_prime;
        r_out   <= n_out;
    end

    assign o_stall    = (r_state != mrp_pkg::S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_is_prime = r_out;

endmodule

`default_nettype wire
